// ----- rtl/core/fltpe_pkg.sv -----
package fltpe_pkg;

	typedef enum logic [1:0] {
		REQ_MAP       = 2'd0,
		REQ_UNMAP     = 2'd1,
		REQ_TRANSLATE = 2'd2,
		REQ_NONE      = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_ABSENT    = 2'd1,
		ST_NO_TABLES = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [47:0] virt_addr;
		logic [51:0] phys_addr;
		logic [11:0] flag_bits;
		logic        no_execute;
	} req_word_t;

	typedef struct packed {
		logic [51:0] phys_result;
		logic [1:0]  status;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_CLEAR,
		S_LEAF,
		S_RESP
	} fsm_t;

	localparam int unsigned IDX_W = 9;
	localparam int unsigned FRAME_W = 40;
	localparam logic [2:0] LINK_FLAGS = 3'h7;

endpackage

// ----- rtl/core/four_level_page_table_engine.sv -----
// Four-level page-table engine.
// Request words enter on req (req_valid / req_stall) and one response word
// per request leaves on rsp (rsp_valid / rsp_stall). A word moves at a rising
// edge where valid is high and stall is low.
// Table entries live in one synchronous memory of TABLE_PAGES*512 words with a
// registered read. Each request reads up to four entries in sequence, a read
// state and an evaluate state per level, then a map or unmap writes the leaf
// entry; the next request is taken only after the response has left its
// output register. Creating a table writes the link entry, then a sweep
// zeroes the new page one entry a cycle, and a resume state restarts the walk.
// One request is handled at a time; req_stall is high while a request is in
// flight and also while the response waits in its output register.
// When rsp_stall holds the response, the block keeps it unchanged and takes
// no new request until it is taken.
// After reset a sweep of its 512 entries clears the root page before the
// first request is taken; base_q, the table frame base, resets to zero.
// Write it by cfg_we / cfg_data only while the block is idle (not enforced).
module four_level_page_table_engine import fltpe_pkg::*; #(
	parameter int unsigned TABLE_PAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [FRAME_W-1:0]  cfg_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_word_t           req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_word_t           rsp
);

	localparam int unsigned PG_W = (TABLE_PAGES > 2) ? $clog2(TABLE_PAGES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_PAGES + 1);
	localparam int unsigned ADDR_W = PG_W + IDX_W;

	logic [63:0] mem [TABLE_PAGES*512];

	fsm_t state_q, state_d;
	logic [FRAME_W-1:0] base_q;
	logic [CNT_W-1:0] next_free_q, next_free_d;
	req_word_t req_q, req_d;
	logic [1:0] lvl_q, lvl_d;
	logic [PG_W-1:0] page_q, page_d;
	logic [IDX_W-1:0] clr_q, clr_d;
	logic rsp_valid_q, rsp_valid_d;
	rsp_word_t rsp_q, rsp_d;

	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [63:0] mem_wdata, rd_q;

	logic [IDX_W-1:0] idx;
	logic [FRAME_W-1:0] rel;
	logic rel_ok;
	logic [FRAME_W-1:0] new_frame;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_comb begin
		unique case (lvl_q)
			2'd0: idx = req_q.virt_addr[47:39];
			2'd1: idx = req_q.virt_addr[38:30];
			2'd2: idx = req_q.virt_addr[29:21];
			default: idx = req_q.virt_addr[20:12];
		endcase
	end

	assign rel = rd_q[12 +: FRAME_W] - base_q;
	assign rel_ok = (rel < FRAME_W'(next_free_q)) && (rel < FRAME_W'(TABLE_PAGES));
	assign new_frame = base_q + FRAME_W'(next_free_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			base_q      <= '0;
			next_free_q <= CNT_W'(1);
			lvl_q       <= '0;
			page_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			next_free_q <= next_free_d;
			lvl_q       <= lvl_d;
			page_q      <= page_d;
			clr_q       <= clr_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_we) begin
				base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q       <= req_d;
		rsp_q       <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		next_free_d = next_free_q;
		req_d       = req_q;
		lvl_d       = lvl_q;
		page_d      = page_q;
		clr_d       = clr_q;
		rsp_valid_d = rsp_valid_q;
		rsp_d       = rsp_q;
		mem_we      = 1'b0;
		mem_waddr   = {page_q, idx};
		mem_wdata   = '0;
		mem_raddr   = {page_q, idx};
		req_stall   = 1'b1;

		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				req_stall = rsp_valid_q;
				if (req_valid && !rsp_valid_q) begin
					req_d  = req;
					lvl_d  = '0;
					page_d = '0;
					state_d = (req.req_type == REQ_NONE) ? S_RESP : S_READ;
					rsp_d  = '{phys_result: '0, status: ST_DONE};
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (lvl_q == 2'd3) begin
					if (req_q.req_type == REQ_MAP) begin
						mem_we    = 1'b1;
						mem_wdata = {req_q.no_execute, 11'd0, req_q.phys_addr[51:12],
							req_q.flag_bits[11:1], 1'b1};
					end else if (req_q.req_type == REQ_UNMAP) begin
						mem_we = 1'b1;
					end else if (!rd_q[0]) begin
						rsp_d.status = ST_ABSENT;
					end else begin
						rsp_d.phys_result = {rd_q[51:12], req_q.virt_addr[11:0]};
					end
					state_d = S_RESP;
				end else if (rd_q[0]) begin
					if (rel_ok) begin
						page_d  = rel[PG_W-1:0];
						lvl_d   = lvl_q + 2'd1;
						state_d = S_READ;
					end else begin
						rsp_d.status = ST_ABSENT;
						state_d = S_RESP;
					end
				end else if (req_q.req_type != REQ_MAP) begin
					rsp_d.status = ST_ABSENT;
					state_d = S_RESP;
				end else if (next_free_q >= CNT_W'(TABLE_PAGES)) begin
					rsp_d.status = ST_NO_TABLES;
					state_d = S_RESP;
				end else begin
					mem_we      = 1'b1;
					mem_wdata   = {12'd0, new_frame, 9'd0, LINK_FLAGS};
					page_d      = next_free_q[PG_W-1:0];
					next_free_d = next_free_q + CNT_W'(1);
					lvl_d       = lvl_q + 2'd1;
					clr_d       = '0;
					state_d     = S_CLEAR;
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {page_q, clr_q};
				clr_d     = clr_q + IDX_W'(1);
				if (clr_q == '1) begin
					state_d = (next_free_q == CNT_W'(1) && lvl_q == 2'd0) ? S_IDLE : S_LEAF;
				end
			end
			S_LEAF: begin
				state_d = S_READ;
			end
			S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// A mapped leaf always has flag bit 0 set; flags bit 0 is absorbed by it.
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_page_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> mem_we)
		else $error("clear sweep without write");
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= CNT_W'(TABLE_PAGES))
		else $error("allocator beyond pool");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> req_stall)
		else $error("request taken while busy");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled response changed");

endmodule

// ----- test/tb_four_level_page_table_engine.sv -----
`timescale 1ns / 1ps

module tb_four_level_page_table_engine;
	import fltpe_pkg::*;

	localparam int PAGES = 16;
	localparam int SLOTS = PAGES * 512;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [FRAME_W-1:0] cfg_data;
	logic               req_valid;
	logic               req_stall;
	req_word_t          req;
	logic               rsp_valid;
	logic               rsp_stall;
	rsp_word_t          rsp;

	logic [63:0]        tbl [0:SLOTS-1];
	int                 free_page;
	logic [39:0]        frame_base;
	rsp_word_t          pending_rsp [$];
	int                 fail_count;

	four_level_page_table_engine #(.TABLE_PAGES(PAGES)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("four_level_page_table_engine: mismatch");
		$finish;
	end

	function automatic status_t walk_levels(input logic [47:0] va, input bit create,
			output int pt);
		int          pg;
		int          slot;
		logic [63:0] e;
		logic [39:0] rel;
		logic [39:0] frame;
		pg = 0;
		pt = 0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			slot = pg * 512 + int'(va[47 - 9 * lvl -: 9]);
			e = tbl[slot];
			if (!e[0]) begin
				if (!create) return ST_ABSENT;
				if (free_page >= PAGES) return ST_NO_TABLES;
				for (int k = 0; k < 512; k++) tbl[free_page * 512 + k] = '0;
				frame = frame_base + 40'(free_page);
				tbl[slot] = {12'h000, frame, 9'h000, LINK_FLAGS};
				pg = free_page;
				free_page++;
			end else begin
				rel = e[51:12] - frame_base;
				if (rel >= 40'(free_page) || rel >= 40'(PAGES)) return ST_ABSENT;
				pg = int'(rel);
			end
		end
		pt = pg;
		return ST_DONE;
	endfunction

	function automatic rsp_word_t apply_request(input req_word_t w);
		rsp_word_t   r;
		status_t     st;
		int          pt;
		int          leaf;
		logic [63:0] e;
		r = '0;
		st = ST_DONE;
		pt = 0;
		case (w.req_type)
			REQ_MAP: begin
				st = walk_levels(w.virt_addr, 1'b1, pt);
				if (st == ST_DONE)
					tbl[pt * 512 + int'(w.virt_addr[20:12])] =
						{w.no_execute, 11'h000, w.phys_addr[51:12], w.flag_bits} | 64'd1;
			end
			REQ_UNMAP: begin
				st = walk_levels(w.virt_addr, 1'b0, pt);
				if (st == ST_DONE) tbl[pt * 512 + int'(w.virt_addr[20:12])] = '0;
			end
			REQ_TRANSLATE: begin
				st = walk_levels(w.virt_addr, 1'b0, pt);
				if (st == ST_DONE) begin
					leaf = pt * 512 + int'(w.virt_addr[20:12]);
					e = tbl[leaf];
					if (!e[0]) st = ST_ABSENT;
					else r.phys_result = {e[51:12], w.virt_addr[11:0]};
				end
			end
			default: ;
		endcase
		r.status = st;
		return r;
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		bit stalled;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end while (stalled);
		pending_rsp.push_back(apply_request(w));
	endtask

	task automatic write_base(input logic [39:0] value);
		if (req_valid) begin
			@(posedge clk);
			req_valid <= 1'b0;
		end
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_base = value;
	endtask

	function automatic req_word_t make_word(input req_type_t kind, input logic [47:0] va,
			input logic [51:0] pa, input logic [11:0] fl, input logic nx);
		req_word_t w;
		w.req_type = kind;
		w.virt_addr = va;
		w.phys_addr = pa;
		w.flag_bits = fl;
		w.no_execute = nx;
		return w;
	endfunction

	function automatic logic [8:0] pick_index();
		case ($urandom_range(0, 3))
			0: return 9'h000;
			1: return 9'h1FF;
			default: return 9'($urandom_range(1, 2));
		endcase
	endfunction

	function automatic req_word_t random_word();
		req_word_t   w;
		int          k;
		logic [47:0] va;
		logic [8:0]  leaf_idx;
		if ($urandom_range(0, 9) < 2) begin
			va = 48'({$urandom, $urandom});
		end else begin
			leaf_idx = ($urandom_range(0, 7) == 0) ? 9'h1FF : 9'($urandom_range(0, 7));
			va = {pick_index(), pick_index(), pick_index(), leaf_idx, 12'($urandom)};
		end
		k = $urandom_range(0, 9);
		w.req_type = (k < 4) ? REQ_MAP : (k < 6) ? REQ_UNMAP : (k < 9) ? REQ_TRANSLATE : REQ_NONE;
		w.virt_addr = va;
		w.phys_addr = 52'({$urandom, $urandom});
		w.flag_bits = 12'($urandom);
		w.no_execute = 1'($urandom);
		return w;
	endfunction

	task automatic test_directed();
		logic [47:0] top;
		top = 48'hFFFF_FFFF_FFFF;
		send_word(make_word(REQ_TRANSLATE, 48'h0, '0, '0, 1'b0));
		send_word(make_word(REQ_UNMAP, 48'h0, '0, '0, 1'b0));
		send_word(make_word(REQ_MAP, 48'h0, '1, '1, 1'b1));
		send_word(make_word(REQ_TRANSLATE, 48'h0, '0, '0, 1'b0));
		send_word(make_word(REQ_TRANSLATE, 48'hFFF, '0, '0, 1'b0));
		send_word(make_word(REQ_MAP, top, 52'h0, 12'h000, 1'b0));
		send_word(make_word(REQ_TRANSLATE, top, '0, '0, 1'b0));
		send_word(make_word(REQ_MAP, top, '1, 12'h000, 1'b0));
		send_word(make_word(REQ_TRANSLATE, top, '0, '0, 1'b0));
		send_word(make_word(REQ_TRANSLATE, 48'h1000, '0, '0, 1'b0));
		send_word(make_word(REQ_UNMAP, 48'h0, '0, '0, 1'b0));
		send_word(make_word(REQ_TRANSLATE, 48'h0, '0, '0, 1'b0));
		send_word(make_word(REQ_NONE, top, '1, '1, 1'b1));
		send_word(make_word(REQ_MAP, 48'h0000_4020_1000, 52'hA_BCDE_F012_3456, 12'h5A5, 1'b1));
		send_word(make_word(REQ_TRANSLATE, 48'h0000_4020_1ABC, '0, '0, 1'b0));
		send_word(make_word(REQ_UNMAP, top, '0, '0, 1'b0));
		send_word(make_word(REQ_TRANSLATE, top, '0, '0, 1'b0));
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) send_word(random_word());
	endtask

	initial begin
		rsp_word_t exp_rsp;
		rsp_word_t got_rsp;
		bit        got;
		int        gap;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = rsp_valid;
				got_rsp = rsp;
				@(posedge clk);
			end while (!got);
			if (pending_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected word: result %h status %0d", got_rsp.phys_result,
						got_rsp.status);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (got_rsp.phys_result !== exp_rsp.phys_result ||
						got_rsp.status !== exp_rsp.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Wrong word: expected %h/%0d, got %h/%0d",
							exp_rsp.phys_result, exp_rsp.status, got_rsp.phys_result,
							got_rsp.status);
				end
			end
		end
	end

	initial begin
		logic [39:0] mid_base;
		fail_count = 0;
		free_page = 1;
		frame_base = '0;
		for (int k = 0; k < SLOTS; k++) tbl[k] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (600) @(posedge clk);
		mid_base = 40'({$urandom, $urandom});
		write_base(mid_base);
		test_directed();
		test_random(350);
		write_base('1);
		test_random(150);
		write_base('0);
		test_random(100);
		write_base(mid_base);
		test_random(200);
		@(posedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("four_level_page_table_engine: match");
		end else begin
			$display("four_level_page_table_engine: mismatch");
		end
		$finish;
	end

endmodule

// ----- four_level_page_table_engine.f -----
rtl/core/fltpe_pkg.sv
rtl/core/four_level_page_table_engine.sv
test/tb_four_level_page_table_engine.sv
